/* rtl/rspd_pkg.sv */
package rspd_pkg;

    // sample magnitude and statistics geometry
    localparam int MAG_WIDTH   = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int MAG_EXT_W   = MAG_WIDTH + 1;

    // fixed field widths
    localparam int DATA_W     = 32;
    localparam int DEV_W      = 32;
    localparam int WHOLE_W    = 7;
    localparam int DIVISOR_W  = 15;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 15;

    // shared arithmetic unit widths
    localparam int OPB_W  = DEV_W;
    localparam int WIDE_W = 2 * OPB_W;

    // sample count thresholds
    localparam int PEAK_MIN_COUNT  = 15;
    localparam int MEAN_PAIR_COUNT = 2;

    localparam logic FUNC_CLEAR = 1'b1;

    typedef logic [WIDE_W-1:0] wide_t;
    typedef logic [OPB_W-1:0]  opb_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD_WHOLE,
        CFG_THRESHOLD_DIVISOR
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_CHECK,
        ST_EMIT
    } st_t;

    typedef enum logic [3:0] {
        STP_MEAN_MUL,
        STP_MEAN_DIV,
        STP_DSQ_MUL,
        STP_DSQ_DIV,
        STP_P1_MUL,
        STP_P2_MUL,
        STP_P3_MUL,
        STP_P3_DIV,
        STP_ROOT,
        STP_THR_MUL,
        STP_THR_DIV
    } step_t;

endpackage

/* rtl/rspd_mul.sv */
module rspd_mul import rspd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  wide_t mul_a,
    input  opb_t  mul_b,
    output logic  busy,
    output wide_t prod
);

    wide_t a_reg;
    opb_t  b_reg;
    wide_t acc_reg;
    logic  busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && b_reg == '0) begin
            busy_reg <= 1'b0;
        end
    end

    // one multiplier bit per cycle, stops once the remaining bits are zero
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= mul_a;
            b_reg   <= mul_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + (b_reg[0] ? a_reg : '0);
            a_reg   <= a_reg << 1;
            b_reg   <= b_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

/* rtl/rspd_div.sv */
module rspd_div import rspd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  wide_t div_a,
    input  opb_t  div_b,
    output logic  busy,
    output wide_t quo
);

    localparam int CNT_W = $clog2(WIDE_W);

    wide_t            quo_reg;
    opb_t             rem_reg;
    opb_t             d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [OPB_W:0]   trial;
    logic [OPB_W:0]   diff;
    logic             fits;

    // restoring step: dividend bits leave the top, quotient bits enter the bottom
    assign trial = {rem_reg, quo_reg[WIDE_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CNT_W'(WIDE_W - 1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= div_a;
            d_reg   <= div_b;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[OPB_W-1:0] : trial[OPB_W-1:0];
            quo_reg <= {quo_reg[WIDE_W-2:0], fits};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/rspd_sqrt.sv */
module rspd_sqrt import rspd_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  wide_t radicand,
    output logic  busy,
    output opb_t  root
);

    localparam int CNT_W = $clog2(OPB_W);

    wide_t            rad_reg;
    logic [OPB_W:0]   rem_reg;
    opb_t             root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [OPB_W+2:0] t;
    logic [OPB_W+2:0] trial;
    logic [OPB_W+2:0] diff;
    logic             fits;

    // two radicand bits per cycle, one root bit out
    assign t     = {rem_reg, rad_reg[WIDE_W-1:WIDE_W-2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign diff  = t - trial;
    assign fits  = t >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CNT_W'(OPB_W - 1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[OPB_W:0] : t[OPB_W:0];
            root_reg <= {root_reg[OPB_W-2:0], fits};
            rad_reg  <= rad_reg << 2;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* rtl/running_stats_peak_detector_unit.sv */
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata: sample_magnitude, sample_time; tuser: func
// m_        out  m_tvalid/m_tready  tdata: peak_magnitude, peak_time
// cfg_      in   cfg_wen            cfg_addr register index, cfg_wdata value
//
// After a sample is accepted, s_tready stays low until the sequencer is idle again, plus any wait for
// the output register; a clear request is taken while idle and leaves the sequencer idle. The serial
// units set the run time: each step passes through an issue state and a wait state, and the
// multiplier stops once its remaining multiplier bits are zero.
// Reset (aresetn low, synchronous) zeroes the statistics and loads the thresholds 1 and 5.
// s_tready is high only while idle; a peak waits in the output register while the next
// sample runs, and the sequencer holds a new peak until that register is free.
module running_stats_peak_detector_unit import rspd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*DATA_W-1:0]   s_tdata,   // [31:0] sample_magnitude, [63:32] sample_time
    input  logic [0:0]            s_tuser,   // [0] func

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*DATA_W-1:0]   m_tdata,   // [31:0] peak_magnitude, [63:32] peak_time

    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    st_t   state_reg, state_next;
    step_t step_reg, step_next;

    logic [WHOLE_W-1:0]           whole_reg;
    logic [DIVISOR_W-1:0]         div_reg;
    logic signed [MAG_WIDTH-1:0]  mean_reg;
    logic signed [MAG_WIDTH-1:0]  old_mean_reg;
    logic signed [MAG_WIDTH-1:0]  x_reg;
    logic [DEV_W-1:0]             dev_reg;
    logic [COUNT_WIDTH-1:0]       count_reg;
    logic [DATA_W-1:0]            time_reg;
    wide_t                        wide_reg;
    wide_t                        s_reg;
    logic                         m_tvalid_reg;
    logic [DATA_W-1:0]            peak_mag_reg;
    logic [DATA_W-1:0]            peak_time_reg;

    logic mul_start, div_start, sqrt_start;
    logic mul_busy, div_busy, sqrt_busy;
    wide_t mul_a, mul_prod, div_a, div_quo;
    opb_t  mul_b, div_b, sqrt_root;

    logic unit_idle, step_is_mul, step_is_div;
    logic n_is_one, n_is_two, n_gt_min, peak, out_free;
    logic [COUNT_WIDTH-1:0] n_m1, n_m2, count_inc;

    logic [MAG_WIDTH-1:0]        abs_o, abs_om, abs_xm;
    logic signed [MAG_EXT_W-1:0] diff_om, diff_xm;

    function automatic wide_t sat_add(input wide_t a, input wide_t b);
        logic [WIDE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WIDE_W] ? '1 : s[WIDE_W-1:0];
    endfunction

    rspd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .busy    (mul_busy),
        .prod    (mul_prod)
    );

    rspd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .div_a   (div_a),
        .div_b   (div_b),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    rspd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (s_reg),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    assign n_is_one  = count_reg == COUNT_WIDTH'(1);
    assign n_is_two  = count_reg == COUNT_WIDTH'(MEAN_PAIR_COUNT);
    assign n_gt_min  = count_reg > COUNT_WIDTH'(PEAK_MIN_COUNT);
    assign n_m1      = count_reg - COUNT_WIDTH'(1);
    assign n_m2      = count_reg - COUNT_WIDTH'(2);
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_WIDTH'(1);

    assign abs_o   = old_mean_reg[MAG_WIDTH-1] ? MAG_WIDTH'(-old_mean_reg)
                                               : MAG_WIDTH'(old_mean_reg);
    assign diff_om = MAG_EXT_W'(old_mean_reg) - MAG_EXT_W'(mean_reg);
    assign diff_xm = MAG_EXT_W'(x_reg) - MAG_EXT_W'(mean_reg);
    assign abs_om  = diff_om[MAG_WIDTH] ? MAG_WIDTH'(-diff_om) : MAG_WIDTH'(diff_om);
    assign abs_xm  = diff_xm[MAG_WIDTH] ? MAG_WIDTH'(-diff_xm) : MAG_WIDTH'(diff_xm);

    // wide_reg holds the threshold once the check state is reached
    assign peak     = !diff_xm[MAG_WIDTH] && (wide_t'(diff_xm) > wide_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        step_is_mul = 1'b0;
        step_is_div = 1'b0;
        unique case (step_reg)
            STP_MEAN_MUL, STP_DSQ_MUL, STP_P1_MUL, STP_P2_MUL, STP_P3_MUL,
            STP_THR_MUL: step_is_mul = 1'b1;
            STP_MEAN_DIV, STP_DSQ_DIV, STP_P3_DIV, STP_THR_DIV: step_is_div = 1'b1;
            STP_ROOT: ;
        endcase
    end

    assign unit_idle = step_is_mul ? !mul_busy : (step_is_div ? !div_busy : !sqrt_busy);

    // operand selection for the shared units
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        div_a = '0;
        div_b = '0;
        unique case (step_reg)
            STP_MEAN_MUL: begin
                mul_a = wide_t'(abs_o);
                mul_b = opb_t'(n_m1);
            end
            STP_MEAN_DIV: begin
                div_a = wide_reg[WIDE_W-1] ? -wide_reg : wide_reg;
                div_b = opb_t'(count_reg);
            end
            STP_DSQ_MUL: begin
                mul_a = wide_t'(dev_reg);
                mul_b = opb_t'(dev_reg);
            end
            STP_DSQ_DIV: begin
                div_a = wide_reg;
                div_b = opb_t'(n_m1);
            end
            STP_P1_MUL: begin
                mul_a = wide_reg;
                mul_b = opb_t'(n_m2);
            end
            STP_P2_MUL: begin
                mul_a = wide_t'(abs_om);
                mul_b = opb_t'(abs_om);
            end
            STP_P3_MUL: begin
                mul_a = wide_t'(abs_xm);
                mul_b = opb_t'(abs_xm);
            end
            STP_P3_DIV: begin
                div_a = wide_reg;
                div_b = opb_t'(count_reg);
            end
            STP_ROOT: ;
            STP_THR_MUL: begin
                mul_a = wide_t'(dev_reg);
                mul_b = opb_t'(whole_reg);
            end
            STP_THR_DIV: begin
                div_a = wide_t'(dev_reg);
                div_b = opb_t'(div_reg);
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser[0] != FUNC_CLEAR) begin
                    state_next = ST_ISSUE;
                    step_next  = STP_MEAN_MUL;
                end
            end
            ST_ISSUE: state_next = ST_WAIT;
            ST_WAIT: begin
                if (unit_idle) begin
                    state_next = ST_ISSUE;
                    unique case (step_reg)
                        STP_MEAN_MUL: step_next = STP_MEAN_DIV;
                        STP_MEAN_DIV: begin
                            priority if (n_is_one) begin
                                state_next = ST_IDLE;
                            end else if (n_is_two) begin
                                step_next = STP_P2_MUL;
                            end else begin
                                step_next = STP_DSQ_MUL;
                            end
                        end
                        STP_DSQ_MUL: step_next = STP_DSQ_DIV;
                        STP_DSQ_DIV: step_next = STP_P1_MUL;
                        STP_P1_MUL:  step_next = STP_P2_MUL;
                        STP_P2_MUL:  step_next = STP_P3_MUL;
                        STP_P3_MUL:  step_next = n_is_two ? STP_ROOT : STP_P3_DIV;
                        STP_P3_DIV:  step_next = STP_ROOT;
                        STP_ROOT: begin
                            if (n_gt_min) begin
                                step_next = STP_THR_MUL;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                        STP_THR_MUL: begin
                            if (div_reg != '0) begin
                                step_next = STP_THR_DIV;
                            end else begin
                                state_next = ST_CHECK;
                            end
                        end
                        STP_THR_DIV: state_next = ST_CHECK;
                    endcase
                end
            end
            ST_CHECK: state_next = peak ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready   = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_ISSUE: begin
                mul_start  = step_is_mul;
                div_start  = step_is_div;
                sqrt_start = !step_is_mul && !step_is_div;
            end
            ST_WAIT, ST_CHECK, ST_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= STP_MEAN_MUL;
            whole_reg    <= WHOLE_W'(1);
            div_reg      <= DIVISOR_W'(5);
            mean_reg     <= '0;
            dev_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (cfg_wen) begin
                unique case (cfg_addr)
                    CFG_THRESHOLD_WHOLE:   whole_reg <= cfg_wdata[WHOLE_W-1:0];
                    CFG_THRESHOLD_DIVISOR: div_reg   <= cfg_wdata[DIVISOR_W-1:0];
                endcase
            end

            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == FUNC_CLEAR) begin
                    mean_reg  <= '0;
                    dev_reg   <= '0;
                    count_reg <= '0;
                end else begin
                    count_reg    <= count_inc;
                    old_mean_reg <= mean_reg;
                    x_reg        <= $signed(s_tdata[MAG_WIDTH-1:0]);
                    time_reg     <= s_tdata[2*DATA_W-1:DATA_W];
                end
            end

            if (state_reg == ST_WAIT && unit_idle) begin
                unique case (step_reg)
                    // signed numerator x + (n-1)*o
                    STP_MEAN_MUL: wide_reg <= old_mean_reg[MAG_WIDTH-1]
                                              ? wide_t'(x_reg) - mul_prod
                                              : wide_t'(x_reg) + mul_prod;
                    STP_MEAN_DIV: begin
                        mean_reg <= wide_reg[WIDE_W-1] ? -$signed(div_quo[MAG_WIDTH-1:0])
                                                       : $signed(div_quo[MAG_WIDTH-1:0]);
                        s_reg    <= '0;
                        if (n_is_one) begin
                            dev_reg <= '0;
                        end
                    end
                    STP_DSQ_MUL: wide_reg <= mul_prod;
                    STP_DSQ_DIV: wide_reg <= div_quo;
                    STP_P1_MUL:  s_reg    <= mul_prod;
                    STP_P2_MUL:  s_reg    <= sat_add(s_reg, mul_prod);
                    STP_P3_MUL: begin
                        if (n_is_two) begin
                            s_reg <= sat_add(s_reg, mul_prod);
                        end else begin
                            wide_reg <= mul_prod;
                        end
                    end
                    STP_P3_DIV:  s_reg    <= sat_add(s_reg, div_quo);
                    STP_ROOT:    dev_reg  <= n_is_two ? (sqrt_root >> 1) : sqrt_root;
                    STP_THR_MUL: wide_reg <= mul_prod;
                    STP_THR_DIV: wide_reg <= wide_reg + div_quo;
                endcase
            end

            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg  <= 1'b1;
                peak_mag_reg  <= DATA_W'(x_reg);
                peak_time_reg <= time_reg;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {peak_time_reg, peak_mag_reg};

endmodule
